// ----- rtl/pcr_pkg.sv -----
package pcr_pkg;

    localparam int COORD_WIDTH  = 10;
    localparam int RADIUS_WIDTH = 8;
    localparam int RESULT_WIDTH = 12;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(12);

    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 1;
    localparam int ROOT_WIDTH  = COORD_WIDTH + 1;
    localparam int TRIAL_WIDTH = SUM_WIDTH + 2;
    localparam int PROD_WIDTH  = COORD_WIDTH + RADIUS_WIDTH;
    localparam int DIV_WIDTH   = PROD_WIDTH + 1;
    localparam int QUOT_WIDTH  = RADIUS_WIDTH;
    localparam int EXT_WIDTH   = DIFF_WIDTH + 1;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] target_x;
        logic [COORD_WIDTH-1:0] target_y;
        logic [COORD_WIDTH-1:0] center_x;
        logic [COORD_WIDTH-1:0] center_y;
    } pt_in_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] result_x;
        logic signed [RESULT_WIDTH-1:0] result_y;
    } pt_out_t;

    // per-item values carried alongside the arithmetic
    typedef struct packed {
        logic [COORD_WIDTH-1:0]        cx;
        logic [COORD_WIDTH-1:0]        cy;
        logic signed [DIFF_WIDTH-1:0]  dx;
        logic signed [DIFF_WIDTH-1:0]  dy;
        logic [COORD_WIDTH-1:0]        ax;
        logic [COORD_WIDTH-1:0]        ay;
    } pcr_carry_t;

endpackage

// ----- rtl/point_clamp_to_radius.sv -----
// Clamps a point to lie within max_radius of a center. The offset dx, dy is
// measured, its length taken as the floor integer square root of dx^2 + dy^2,
// and if that length exceeds max_radius each offset becomes
// offset * max_radius / length (truncated toward zero); result = center + offset.
// Fully pipelined: one item per cycle while the result is not stalled, built from
// the one-bit-per-stage square root and the one-bit-per-stage dividers. A stalled
// result freezes the whole pipeline. max_radius resets to 12; the user must write
// it with max_radius_we only while no item is in flight, which the block itself
// does not enforce.
module point_clamp_to_radius
    import pcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    point_valid,
    output logic                    point_stall,
    input  pt_in_t                  point,
    output logic                    result_valid,
    input  logic                    result_stall,
    output pt_out_t                 result,
    input  logic                    max_radius_we,
    input  logic [RADIUS_WIDTH-1:0] max_radius_data
);

    logic [RADIUS_WIDTH-1:0] radius_reg;
    logic                    adv;

    // front stages
    pcr_carry_t              s1_next;
    pcr_carry_t              s1_reg;
    logic                    s1_valid_reg;
    pcr_carry_t              s2_reg;
    logic                    s2_valid_reg;
    logic [SQ_WIDTH-1:0]     sqx_reg;
    logic [SQ_WIDTH-1:0]     sqy_reg;

    // square root chain, entry 0 holds the sum of squares
    logic [SUM_WIDTH-1:0]    sq_rem_reg   [0:ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]   sq_root_reg  [0:ROOT_WIDTH];
    pcr_carry_t              sq_carry_reg [0:ROOT_WIDTH];
    logic                    sq_valid_reg [0:ROOT_WIDTH];

    // divider chain, entry 0 holds the scaled magnitudes
    logic [PROD_WIDTH-1:0]   dv_rem_x_reg  [0:QUOT_WIDTH];
    logic [PROD_WIDTH-1:0]   dv_rem_y_reg  [0:QUOT_WIDTH];
    logic [QUOT_WIDTH-1:0]   dv_quot_x_reg [0:QUOT_WIDTH];
    logic [QUOT_WIDTH-1:0]   dv_quot_y_reg [0:QUOT_WIDTH];
    logic [ROOT_WIDTH-1:0]   dv_dist_reg   [0:QUOT_WIDTH];
    logic                    dv_clamp_reg  [0:QUOT_WIDTH];
    pcr_carry_t              dv_carry_reg  [0:QUOT_WIDTH];
    logic                    dv_valid_reg  [0:QUOT_WIDTH];

    logic                    result_valid_reg;
    pt_out_t                 result_reg;
    pt_out_t                 result_next;

    assign adv          = !(result_valid_reg && result_stall);
    assign point_stall  = !adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (max_radius_we)
        begin
            radius_reg <= max_radius_data;
        end
    end

    // offsets and their magnitudes
    always_comb
    begin
        s1_next.cx = point.center_x;
        s1_next.cy = point.center_y;
        s1_next.dx = $signed({1'b0, point.target_x}) - $signed({1'b0, point.center_x});
        s1_next.dy = $signed({1'b0, point.target_y}) - $signed({1'b0, point.center_y});
        s1_next.ax = s1_next.dx[DIFF_WIDTH-1] ? COORD_WIDTH'(-s1_next.dx)
                                               : COORD_WIDTH'(s1_next.dx);
        s1_next.ay = s1_next.dy[DIFF_WIDTH-1] ? COORD_WIDTH'(-s1_next.dy)
                                               : COORD_WIDTH'(s1_next.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= point_valid;
            s2_valid_reg    <= s1_valid_reg;
            sq_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg          <= s1_next;
            s2_reg          <= s1_reg;
            sqx_reg         <= SQ_WIDTH'(s1_reg.ax) * SQ_WIDTH'(s1_reg.ax);
            sqy_reg         <= SQ_WIDTH'(s1_reg.ay) * SQ_WIDTH'(s1_reg.ay);
            sq_rem_reg[0]   <= SUM_WIDTH'(sqx_reg) + SUM_WIDTH'(sqy_reg);
            sq_root_reg[0]  <= '0;
            sq_carry_reg[0] <= s2_reg;
        end
    end

    // restoring square root, one root bit per stage, msb first
    for (genvar k = 0; k < ROOT_WIDTH; k++)
    begin : g_sqrt
        localparam int B = ROOT_WIDTH - 1 - k;
        logic [TRIAL_WIDTH-1:0] trial;
        logic                   take;
        logic [SUM_WIDTH-1:0]   rem_next;
        logic [ROOT_WIDTH-1:0]  root_next;

        always_comb
        begin
            // (root + 2^B)^2 - root^2
            trial     = (TRIAL_WIDTH'(sq_root_reg[k]) << (B + 1))
                        + (TRIAL_WIDTH'(1) << (2 * B));
            take      = TRIAL_WIDTH'(sq_rem_reg[k]) >= trial;
            rem_next  = take ? SUM_WIDTH'(TRIAL_WIDTH'(sq_rem_reg[k]) - trial)
                             : sq_rem_reg[k];
            root_next = take ? (sq_root_reg[k] | (ROOT_WIDTH'(1) << B))
                             : sq_root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1]   <= rem_next;
                sq_root_reg[k+1]  <= root_next;
                sq_carry_reg[k+1] <= sq_carry_reg[k];
            end
        end
    end

    // clamp decision and scaling by the radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= sq_valid_reg[ROOT_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_dist_reg[0]   <= sq_root_reg[ROOT_WIDTH];
            dv_clamp_reg[0]  <= sq_root_reg[ROOT_WIDTH] > ROOT_WIDTH'(radius_reg);
            dv_rem_x_reg[0]  <= PROD_WIDTH'(sq_carry_reg[ROOT_WIDTH].ax)
                                * PROD_WIDTH'(radius_reg);
            dv_rem_y_reg[0]  <= PROD_WIDTH'(sq_carry_reg[ROOT_WIDTH].ay)
                                * PROD_WIDTH'(radius_reg);
            dv_quot_x_reg[0] <= '0;
            dv_quot_y_reg[0] <= '0;
            dv_carry_reg[0]  <= sq_carry_reg[ROOT_WIDTH];
        end
    end

    // restoring dividers, quotient never exceeds the radius since |d| <= dist
    for (genvar k = 0; k < QUOT_WIDTH; k++)
    begin : g_div
        localparam int B = QUOT_WIDTH - 1 - k;
        logic [DIV_WIDTH-1:0]  shifted;
        logic                  take_x;
        logic                  take_y;
        logic [PROD_WIDTH-1:0] rem_x_next;
        logic [PROD_WIDTH-1:0] rem_y_next;
        logic [QUOT_WIDTH-1:0] quot_x_next;
        logic [QUOT_WIDTH-1:0] quot_y_next;

        always_comb
        begin
            shifted     = DIV_WIDTH'(dv_dist_reg[k]) << B;
            take_x      = DIV_WIDTH'(dv_rem_x_reg[k]) >= shifted;
            take_y      = DIV_WIDTH'(dv_rem_y_reg[k]) >= shifted;
            rem_x_next  = take_x ? PROD_WIDTH'(DIV_WIDTH'(dv_rem_x_reg[k]) - shifted)
                                 : dv_rem_x_reg[k];
            rem_y_next  = take_y ? PROD_WIDTH'(DIV_WIDTH'(dv_rem_y_reg[k]) - shifted)
                                 : dv_rem_y_reg[k];
            quot_x_next = take_x ? (dv_quot_x_reg[k] | (QUOT_WIDTH'(1) << B))
                                 : dv_quot_x_reg[k];
            quot_y_next = take_y ? (dv_quot_y_reg[k] | (QUOT_WIDTH'(1) << B))
                                 : dv_quot_y_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_x_reg[k+1]  <= rem_x_next;
                dv_rem_y_reg[k+1]  <= rem_y_next;
                dv_quot_x_reg[k+1] <= quot_x_next;
                dv_quot_y_reg[k+1] <= quot_y_next;
                dv_dist_reg[k+1]   <= dv_dist_reg[k];
                dv_clamp_reg[k+1]  <= dv_clamp_reg[k];
                dv_carry_reg[k+1]  <= dv_carry_reg[k];
            end
        end
    end

    // sign back onto the quotient and add the center
    always_comb
    begin
        logic signed [DIFF_WIDTH-1:0] qx;
        logic signed [DIFF_WIDTH-1:0] qy;
        logic signed [DIFF_WIDTH-1:0] ox;
        logic signed [DIFF_WIDTH-1:0] oy;
        logic signed [EXT_WIDTH-1:0]  sx;
        logic signed [EXT_WIDTH-1:0]  sy;
        pcr_carry_t                   c;

        c  = dv_carry_reg[QUOT_WIDTH];
        qx = $signed(DIFF_WIDTH'(dv_quot_x_reg[QUOT_WIDTH]));
        qy = $signed(DIFF_WIDTH'(dv_quot_y_reg[QUOT_WIDTH]));
        ox = c.dx;
        oy = c.dy;
        if (dv_clamp_reg[QUOT_WIDTH])
        begin
            ox = c.dx[DIFF_WIDTH-1] ? -qx : qx;
            oy = c.dy[DIFF_WIDTH-1] ? -qy : qy;
        end
        sx = $signed({2'b00, c.cx}) + EXT_WIDTH'(ox);
        sy = $signed({2'b00, c.cy}) + EXT_WIDTH'(oy);
        result_next.result_x = RESULT_WIDTH'(sx);
        result_next.result_y = RESULT_WIDTH'(sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= dv_valid_reg[QUOT_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    // root is the floor: remainder v - root^2 stays within 2*root
    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[ROOT_WIDTH] |->
            (SUM_WIDTH'(sq_rem_reg[ROOT_WIDTH])
             <= (SUM_WIDTH'(sq_root_reg[ROOT_WIDTH]) << 1)))
        else $error("square root remainder too large");

    // the quotient fit in its width: final remainder below the divisor
    a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QUOT_WIDTH] && dv_clamp_reg[QUOT_WIDTH]) |->
            (DIV_WIDTH'(dv_rem_x_reg[QUOT_WIDTH]) < DIV_WIDTH'(dv_dist_reg[QUOT_WIDTH])
             && DIV_WIDTH'(dv_rem_y_reg[QUOT_WIDTH])
                < DIV_WIDTH'(dv_dist_reg[QUOT_WIDTH])))
        else $error("divider quotient overflow");

    // a held result freezes the inner stages
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=>
            ($stable(sq_valid_reg[ROOT_WIDTH]) && $stable(dv_valid_reg[QUOT_WIDTH])
             && $stable(s1_valid_reg)))
        else $error("pipeline moved while result stalled");

endmodule
